>>> design/heap_sort_descending_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heap sort block
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_DESCENDING_ASSERT_SVH
`define HEAP_SORT_DESCENDING_ASSERT_SVH

// Same-cycle implication.
`define HSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Control word layout and status bundle shared by the sequencer and datapath.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // Width of the step counter.
  localparam int unsigned PcW = 5;

  // Store read address select.
  typedef enum logic [2:0] {
    RA_AT    = 3'd0,
    RA_LEFT  = 3'd1,
    RA_RIGHT = 3'd2,
    RA_KM1   = 3'd3,
    RA_K     = 3'd4,
    RA_ZERO  = 3'd5
  } raddr_e;

  // Store write select.
  typedef enum logic [2:0] {
    WR_NONE      = 3'd0,
    WR_AT_PVAL   = 3'd1,
    WR_PICK_AVAL = 3'd2,
    WR_ZERO_RD   = 3'd3,
    WR_KM1_AVAL  = 3'd4
  } wr_e;

  // Loop counter update.
  typedef enum logic [2:0] {
    K_HOLD   = 3'd0,
    K_HALF_N = 3'd1,
    K_N      = 3'd2,
    K_DEC    = 3'd3,
    K_INC    = 3'd4,
    K_ZERO   = 3'd5
  } k_op_e;

  // Sift node update.
  typedef enum logic [1:0] {
    AT_HOLD = 2'd0,
    AT_KM1  = 2'd1,
    AT_ZERO = 2'd2,
    AT_PICK = 2'd3
  } at_op_e;

  // Heap size update.
  typedef enum logic [1:0] {
    SZ_HOLD = 2'd0,
    SZ_N    = 2'd1,
    SZ_KM1  = 2'd2
  } size_op_e;

  // Smallest-of-three tracking.
  typedef enum logic [1:0] {
    PK_HOLD  = 2'd0,
    PK_AT    = 2'd1,
    PK_CMP_L = 2'd2,
    PK_CMP_R = 2'd3
  } pick_op_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NOT_GO    = 4'd2,
    C_K_ZERO    = 4'd3,
    C_K_LE1     = 4'd4,
    C_LEFT_OUT  = 4'd5,
    C_RIGHT_OUT = 4'd6,
    C_PICK_AT   = 4'd7,
    C_NOT_KLAST = 4'd8
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    raddr_e           raddr;
    wr_e              wr;
    k_op_e            k_op;
    at_op_e           at_op;
    size_op_e         size_op;
    pick_op_e         pick_op;
    logic             aval_ld;
    logic             emit;
    logic             clr_n;
    logic             idle;
    cond_e            cond;
    logic             call;
    logic             ret;
    logic [PcW-1:0]   target;
  } ctrl_t;

  // Datapath flags tested by the sequencer.
  typedef struct packed {
    logic go;
    logic k_zero;
    logic k_le1;
    logic left_out;
    logic right_out;
    logic pick_at;
    logic k_last;
  } status_t;

endpackage

>>> design/hsd_sequencer.sv
// ----------------------------------------------------------------------------
// hsd_sequencer
// Step counter, return register and control program table.
// ----------------------------------------------------------------------------
module hsd_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsd_pkg::status_t status_i,
  output hsd_pkg::ctrl_t   ctrl_o
);

  localparam int unsigned PcW = hsd_pkg::PcW;

  // Program step addresses.
  localparam logic [PcW-1:0] StIdle  = 5'd0;
  localparam logic [PcW-1:0] StBInit = 5'd1;
  localparam logic [PcW-1:0] StBChk  = 5'd2;
  localparam logic [PcW-1:0] StBLoop = 5'd3;
  localparam logic [PcW-1:0] StBRet  = 5'd4;
  localparam logic [PcW-1:0] StEInit = 5'd5;
  localparam logic [PcW-1:0] StEChk  = 5'd6;
  localparam logic [PcW-1:0] StE0    = 5'd7;
  localparam logic [PcW-1:0] StE1    = 5'd8;
  localparam logic [PcW-1:0] StE2    = 5'd9;
  localparam logic [PcW-1:0] StE3    = 5'd10;
  localparam logic [PcW-1:0] StERet  = 5'd11;
  localparam logic [PcW-1:0] StOInit = 5'd12;
  localparam logic [PcW-1:0] StORd   = 5'd13;
  localparam logic [PcW-1:0] StOEmit = 5'd14;
  localparam logic [PcW-1:0] StFin   = 5'd15;
  localparam logic [PcW-1:0] StSf0   = 5'd16;
  localparam logic [PcW-1:0] StSf1   = 5'd17;
  localparam logic [PcW-1:0] StSf2   = 5'd18;
  localparam logic [PcW-1:0] StSf3   = 5'd19;
  localparam logic [PcW-1:0] StSf4   = 5'd20;
  localparam logic [PcW-1:0] StSf5   = 5'd21;
  localparam logic [PcW-1:0] StSf6   = 5'd22;
  localparam logic [PcW-1:0] StSf7   = 5'd23;

  logic [PcW-1:0] pc_q, pc_d;
  logic [PcW-1:0] ret_q, ret_d;
  logic [PcW-1:0] pc_inc;
  hsd_pkg::ctrl_t cw;
  logic           taken;

  // Control program. Each word starts as a no-op and sets what it needs.
  always_comb begin
    cw = '{raddr: hsd_pkg::RA_ZERO, wr: hsd_pkg::WR_NONE, k_op: hsd_pkg::K_HOLD,
           at_op: hsd_pkg::AT_HOLD, size_op: hsd_pkg::SZ_HOLD,
           pick_op: hsd_pkg::PK_HOLD, aval_ld: 1'b0, emit: 1'b0, clr_n: 1'b0,
           idle: 1'b0, cond: hsd_pkg::C_NEVER, call: 1'b0, ret: 1'b0,
           target: StIdle};
    unique case (pc_q)
      // Collect words until the last one arrives.
      StIdle: begin
        cw.idle   = 1'b1;
        cw.cond   = hsd_pkg::C_NOT_GO;
        cw.target = StIdle;
      end
      // Heap build: sift down every inner node from the bottom up.
      StBInit: cw.k_op = hsd_pkg::K_HALF_N;
      StBChk: begin
        cw.cond   = hsd_pkg::C_K_ZERO;
        cw.target = StEInit;
      end
      StBLoop: begin
        cw.at_op   = hsd_pkg::AT_KM1;
        cw.size_op = hsd_pkg::SZ_N;
        cw.call    = 1'b1;
        cw.target  = StSf0;
      end
      StBRet: begin
        cw.k_op   = hsd_pkg::K_DEC;
        cw.cond   = hsd_pkg::C_ALWAYS;
        cw.target = StBChk;
      end
      // Extraction: swap the root with the heap end, then sift the root.
      StEInit: cw.k_op = hsd_pkg::K_N;
      StEChk: begin
        cw.cond   = hsd_pkg::C_K_LE1;
        cw.target = StOInit;
      end
      StE0: cw.raddr = hsd_pkg::RA_ZERO;
      StE1: begin
        cw.aval_ld = 1'b1;
        cw.raddr   = hsd_pkg::RA_KM1;
      end
      StE2: cw.wr = hsd_pkg::WR_ZERO_RD;
      StE3: begin
        cw.wr      = hsd_pkg::WR_KM1_AVAL;
        cw.at_op   = hsd_pkg::AT_ZERO;
        cw.size_op = hsd_pkg::SZ_KM1;
        cw.call    = 1'b1;
        cw.target  = StSf0;
      end
      StERet: begin
        cw.k_op   = hsd_pkg::K_DEC;
        cw.cond   = hsd_pkg::C_ALWAYS;
        cw.target = StEChk;
      end
      // Output: read each entry and put it on the result ports.
      StOInit: cw.k_op = hsd_pkg::K_ZERO;
      StORd:   cw.raddr = hsd_pkg::RA_K;
      StOEmit: begin
        cw.emit   = 1'b1;
        cw.k_op   = hsd_pkg::K_INC;
        cw.cond   = hsd_pkg::C_NOT_KLAST;
        cw.target = StORd;
      end
      StFin: begin
        cw.clr_n  = 1'b1;
        cw.cond   = hsd_pkg::C_ALWAYS;
        cw.target = StIdle;
      end
      // Sift-down subroutine on node at within size entries.
      StSf0: cw.raddr = hsd_pkg::RA_AT;
      StSf1: cw.aval_ld = 1'b1;
      StSf2: begin
        cw.pick_op = hsd_pkg::PK_AT;
        cw.raddr   = hsd_pkg::RA_LEFT;
        cw.cond    = hsd_pkg::C_LEFT_OUT;
        cw.ret     = 1'b1;
      end
      StSf3: begin
        cw.pick_op = hsd_pkg::PK_CMP_L;
        cw.raddr   = hsd_pkg::RA_RIGHT;
        cw.cond    = hsd_pkg::C_RIGHT_OUT;
        cw.target  = StSf5;
      end
      StSf4: cw.pick_op = hsd_pkg::PK_CMP_R;
      StSf5: begin
        cw.cond = hsd_pkg::C_PICK_AT;
        cw.ret  = 1'b1;
      end
      StSf6: cw.wr = hsd_pkg::WR_AT_PVAL;
      StSf7: begin
        cw.wr     = hsd_pkg::WR_PICK_AVAL;
        cw.at_op  = hsd_pkg::AT_PICK;
        cw.cond   = hsd_pkg::C_ALWAYS;
        cw.target = StSf2;
      end
      default: begin
        cw.cond   = hsd_pkg::C_ALWAYS;
        cw.target = StIdle;
      end
    endcase
  end

  // Condition select.
  always_comb begin
    unique case (cw.cond)
      hsd_pkg::C_NEVER:     taken = 1'b0;
      hsd_pkg::C_ALWAYS:    taken = 1'b1;
      hsd_pkg::C_NOT_GO:    taken = !status_i.go;
      hsd_pkg::C_K_ZERO:    taken = status_i.k_zero;
      hsd_pkg::C_K_LE1:     taken = status_i.k_le1;
      hsd_pkg::C_LEFT_OUT:  taken = status_i.left_out;
      hsd_pkg::C_RIGHT_OUT: taken = status_i.right_out;
      hsd_pkg::C_PICK_AT:   taken = status_i.pick_at;
      hsd_pkg::C_NOT_KLAST: taken = !status_i.k_last;
      default:              taken = 1'b0;
    endcase
  end

  // Next step: call, taken jump (or return), or fall through.
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    ret_d = ret_q;
    pc_d  = pc_inc;
    if (cw.call) begin
      ret_d = pc_inc;
      pc_d  = cw.target;
    end else if (taken) begin
      pc_d = cw.ret ? ret_q : cw.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= StIdle;
      ret_q <= StIdle;
    end else begin
      pc_q  <= pc_d;
      ret_q <= ret_d;
    end
  end

  assign ctrl_o = cw;

endmodule

>>> design/hsd_datapath.sv
// ----------------------------------------------------------------------------
// hsd_datapath
// Element store with one read and one write port, index registers and the
// signed compare that the control program steers.
// ----------------------------------------------------------------------------
`include "heap_sort_descending_assert.svh"

module hsd_datapath #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsd_pkg::ctrl_t     ctrl_i,
  input  logic               accept_i,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output hsd_pkg::status_t   status_o,
  output logic signed [31:0] value_res_o,
  output logic               last_res_o
);

  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LW    = AddrW + 2;

  logic signed [31:0] mem_q [MAX_ELEMENTS];
  logic signed [31:0] rdata_q;
  logic signed [31:0] aval_q, pval_q, pval_d;
  logic [CntW-1:0]    n_q, k_q, k_d, size_q, size_d;
  logic [AddrW-1:0]   at_q, at_d, pick_q, pick_d;
  logic [CntW-1:0]    km1;
  logic [LW-1:0]      left, right, size_ext;
  logic [AddrW-1:0]   raddr, waddr;
  logic signed [31:0] wdata;
  logic               wr_en;
  logic               room;
  logic [CntW:0]      k_plus1;

  assign km1      = k_q - 1'b1;
  assign left     = {1'b0, at_q, 1'b1};
  assign right    = left + 1'b1;
  assign size_ext = LW'(size_q);
  assign room     = (n_q < CntW'(MAX_ELEMENTS));
  assign k_plus1  = {1'b0, k_q} + 1'b1;

  // Read address select.
  always_comb begin
    case (ctrl_i.raddr)
      hsd_pkg::RA_AT:    raddr = at_q;
      hsd_pkg::RA_LEFT:  raddr = left[AddrW-1:0];
      hsd_pkg::RA_RIGHT: raddr = right[AddrW-1:0];
      hsd_pkg::RA_KM1:   raddr = km1[AddrW-1:0];
      hsd_pkg::RA_K:     raddr = k_q[AddrW-1:0];
      default:           raddr = '0;
    endcase
  end

  // Write port: load words while idle, swaps while sorting.
  always_comb begin
    wr_en = 1'b1;
    waddr = n_q[AddrW-1:0];
    wdata = value_i;
    case (ctrl_i.wr)
      hsd_pkg::WR_AT_PVAL: begin
        waddr = at_q;
        wdata = pval_q;
      end
      hsd_pkg::WR_PICK_AVAL: begin
        waddr = pick_q;
        wdata = aval_q;
      end
      hsd_pkg::WR_ZERO_RD: begin
        waddr = '0;
        wdata = rdata_q;
      end
      hsd_pkg::WR_KM1_AVAL: begin
        waddr = km1[AddrW-1:0];
        wdata = aval_q;
      end
      default: wr_en = accept_i && room;
    endcase
  end

  // Element store.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Register updates requested by the control word.
  always_comb begin
    case (ctrl_i.k_op)
      hsd_pkg::K_HALF_N: k_d = n_q >> 1;
      hsd_pkg::K_N:      k_d = n_q;
      hsd_pkg::K_DEC:    k_d = km1;
      hsd_pkg::K_INC:    k_d = k_plus1[CntW-1:0];
      hsd_pkg::K_ZERO:   k_d = '0;
      default:           k_d = k_q;
    endcase
    case (ctrl_i.at_op)
      hsd_pkg::AT_KM1:  at_d = km1[AddrW-1:0];
      hsd_pkg::AT_ZERO: at_d = '0;
      hsd_pkg::AT_PICK: at_d = pick_q;
      default:          at_d = at_q;
    endcase
    case (ctrl_i.size_op)
      hsd_pkg::SZ_N:   size_d = n_q;
      hsd_pkg::SZ_KM1: size_d = km1;
      default:         size_d = size_q;
    endcase
    pick_d = pick_q;
    pval_d = pval_q;
    case (ctrl_i.pick_op)
      hsd_pkg::PK_AT: begin
        pick_d = at_q;
        pval_d = aval_q;
      end
      hsd_pkg::PK_CMP_L: begin
        if (rdata_q < pval_q) begin
          pick_d = left[AddrW-1:0];
          pval_d = rdata_q;
        end
      end
      hsd_pkg::PK_CMP_R: begin
        if (rdata_q < pval_q) begin
          pick_d = right[AddrW-1:0];
          pval_d = rdata_q;
        end
      end
      default: ;
    endcase
  end

  // Working registers, loaded before every use.
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    at_q   <= at_d;
    size_q <= size_d;
    pick_q <= pick_d;
    pval_q <= pval_d;
    if (ctrl_i.aval_ld) begin
      aval_q <= rdata_q;
    end
  end

  // Element count: grows on each stored word, cleared after the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (ctrl_i.clr_n) begin
      n_q <= '0;
    end else if (accept_i && room) begin
      n_q <= n_q + 1'b1;
    end
  end

  // Flags for the sequencer.
  assign status_o.go        = accept_i && last_i;
  assign status_o.k_zero    = (k_q == '0);
  assign status_o.k_le1     = (k_q <= CntW'(1));
  assign status_o.left_out  = (left >= size_ext);
  assign status_o.right_out = (right >= size_ext);
  assign status_o.pick_at   = (pick_q == at_q);
  assign status_o.k_last    = (k_plus1 == {1'b0, n_q});

  assign value_res_o = rdata_q;
  assign last_res_o  = status_o.k_last;

  // The count never passes the capacity.
  `HSD_ASSERT_IMP(a_count_cap, 1'b1, n_q <= CntW'(MAX_ELEMENTS), "element count overflow")
  // Swaps during a sort stay inside the loaded set.
  `HSD_ASSERT_IMP(a_wr_in_set, wr_en && !accept_i, {1'b0, waddr} < (AddrW+1)'(n_q),
                  "sort write outside the loaded set")
  // After the final word of a run, the finish step empties the store.
  `HSD_ASSERT_NXT(a_run_clears, ctrl_i.emit && status_o.k_last, ##1 (n_q == '0),
                  "store not emptied after the run")

endmodule

>>> design/heap_sort_descending.sv
// ----------------------------------------------------------------------------
// heap_sort_descending
// Collects signed words and returns them sorted in descending order.
// ----------------------------------------------------------------------------
// Usage: raise start with value_i and last_i; a word is taken at a rising
// edge where start is high and busy is low. Words are stored one per cycle
// while busy stays low. Up to MAX_ELEMENTS words are kept; extra words are
// dropped, but a dropped word with last_i set still starts the sort.
// Once a word with last_i set is taken, busy rises and the block sorts the
// set with a min-heap. The run of results follows on value_res_o, each
// marked by a one-cycle res_valid_o pulse; last_res_o marks the final word.
// The receiver must take each word in its cycle. For a set of n words, the
// build runs n/2 sift-downs and the extraction n-1 more. busy falls after
// the last result. Reset empties the set and returns the block to idle.
// ----------------------------------------------------------------------------
module heap_sort_descending #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               res_valid_o,
  output logic signed [31:0] value_res_o,
  output logic               last_res_o
);

  hsd_pkg::ctrl_t   ctrl;
  hsd_pkg::status_t status;
  logic             accept;

  // A word is taken only while the program sits in its idle step.
  assign busy        = !ctrl.idle;
  assign accept      = start && !busy;
  assign res_valid_o = ctrl.emit;

  hsd_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  hsd_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .accept_i    (accept),
    .value_i     (value_i),
    .last_i      (last_i),
    .status_o    (status),
    .value_res_o (value_res_o),
    .last_res_o  (last_res_o)
  );

endmodule
